>>> design/krp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package krp_pkg;

  localparam int REQ_W    = 2;
  localparam int DIM_W    = 15;
  localparam int CODE_W   = 8;
  localparam int KEY_W    = 2 * DIM_W + 2 * CODE_W;
  localparam int HANDLE_W = 6;
  localparam int STATUS_W = 3;
  localparam int FREED_W  = 7;

  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EOF     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_REUSED   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_CREATED  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RELEASED = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_IGNORED  = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_FRAME    = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd6;

  typedef logic [KEY_W-1:0] key_t;

  // Control part of the token that walks down the cell row.
  typedef struct packed {
    logic go;
    logic eof;
    logic done;
    logic created;
  } tok_ctl_t;

endpackage

`default_nettype wire

>>> design/krp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface krp_in_if import krp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [DIM_W-1:0]    key_width;
  logic [DIM_W-1:0]    key_height;
  logic [CODE_W-1:0]   key_format;
  logic [CODE_W-1:0]   key_usage;
  logic [HANDLE_W-1:0] handle_in;
  logic                handle_valid;

  modport source (
    output valid, req_type, key_width, key_height, key_format, key_usage,
           handle_in, handle_valid,
    input  ready
  );

  modport sink (
    input  valid, req_type, key_width, key_height, key_format, key_usage,
           handle_in, handle_valid,
    output ready
  );
endinterface

`default_nettype wire

>>> design/krp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface krp_out_if import krp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle_out;
  logic [FREED_W-1:0]  freed_count;

  modport source (
    output valid, status, handle_out, freed_count,
    input  ready
  );

  modport sink (
    input  valid, status, handle_out, freed_count,
    output ready
  );
endinterface

`default_nettype wire

>>> design/krp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module krp_cell import krp_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire key_t          key_i,
  input  wire logic [CW-1:0] entry_count_i,
  input  wire logic          rel_i,
  input  wire logic [IW-1:0] rel_idx_i,
  input  wire logic          clr_i,
  input  wire tok_ctl_t      tin_ctl_i,
  input  wire logic [IW-1:0] tin_hnd_i,
  input  wire logic [CW-1:0] tin_cnt_i,
  output tok_ctl_t           tout_ctl_o,
  output logic [IW-1:0]      tout_hnd_o,
  output logic [CW-1:0]      tout_cnt_o
);

  key_t          key_r;
  logic          busy_r;
  logic          busy_nxt;
  tok_ctl_t      ctl_r;
  tok_ctl_t      ctl_nxt;
  logic [IW-1:0] hnd_r;
  logic [IW-1:0] hnd_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  logic live;
  logic search;
  logic hit;
  logic make;
  logic drop;
  logic rel_here;

  assign live     = CW'(IDX) < entry_count_i;
  assign search   = tin_ctl_i.go && !tin_ctl_i.eof && !tin_ctl_i.done;
  assign hit      = search && live && !busy_r && (key_r == key_i);
  // The first cell past the live entries takes the new key.
  assign make     = search && !live;
  assign drop     = tin_ctl_i.go && tin_ctl_i.eof && live && busy_r;
  assign rel_here = rel_i && (rel_idx_i == IW'(IDX));

  always_comb begin
    if (clr_i || rel_here) begin
      busy_nxt = 1'b0;
    end else if (hit || make) begin
      busy_nxt = 1'b1;
    end else if (drop) begin
      busy_nxt = 1'b0;
    end else begin
      busy_nxt = busy_r;
    end

    ctl_nxt         = tin_ctl_i;
    ctl_nxt.done    = tin_ctl_i.done || hit || make;
    ctl_nxt.created = tin_ctl_i.created || make;
    hnd_nxt         = (hit || make) ? IW'(IDX) : tin_hnd_i;
    cnt_nxt         = drop ? tin_cnt_i + CW'(1) : tin_cnt_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ctl_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hnd_r <= hnd_nxt;
    cnt_r <= cnt_nxt;
    if (make) begin
      key_r <= key_i;
    end
  end

  assign tout_ctl_o = ctl_r;
  assign tout_hnd_o = hnd_r;
  assign tout_cnt_o = cnt_r;

endmodule

`default_nettype wire

>>> design/keyed_resource_pool.sv
`timescale 1ns / 1ps
`default_nettype none

// Pool of POOL_SIZE keyed entries; the entry index is the handle.
// Requests come in on in_ch, one result per request leaves on out_ch, both
// with valid/ready; a beat moves when valid and ready are high at a clock edge.
// Acquire and end of frame send a token down a row of POOL_SIZE cells, one
// cell per cycle. Each cell holds one key and its in-use mark, and matches,
// appends, or counts a mark as the token passes. Such a request's result is
// registered when the token leaves the last cell, then moved into the output
// register. Release and clear act on all cells at once. One request is worked
// at a time; in_ch.ready is high while no request is in flight, also while the
// previous result still waits on out_ch. If the receiver stalls, the result
// holds on out_ch and a finished request waits in the block until the output
// register frees up. A synchronous active-low reset empties the pool: no live
// entries and all marks clear. Keys are not reset; they are written before
// they are read.

module keyed_resource_pool import krp_pkg::*; #(
  parameter int POOL_SIZE = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  krp_in_if.sink     in_ch,
  krp_out_if.source  out_ch
);

  localparam int IW   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW   = $clog2(POOL_SIZE + 1);
  localparam int CMPW = (CW > HANDLE_W) ? CW : HANDLE_W;
  localparam int HXW  = (IW > HANDLE_W) ? IW : HANDLE_W;
  localparam int FXW  = (CW > FREED_W) ? CW : FREED_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_HOLD} state_t;

  state_t              state_r;
  logic [CW-1:0]       entry_count_r;
  key_t                key_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [HANDLE_W-1:0] res_handle_r;
  logic [FREED_W-1:0]  res_freed_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [FREED_W-1:0]  out_freed_r;

  logic          accept;
  logic          launch;
  key_t          in_key;
  key_t          key_bc;
  logic [CMPW-1:0] hin_x;
  logic [CMPW-1:0] ec_x;
  logic          rel_ok;
  logic          rel_go;
  logic          clr_go;
  logic [IW-1:0] rel_idx;
  logic [HXW-1:0] tail_hnd_x;
  logic [FXW-1:0] tail_cnt_x;

  tok_ctl_t      link_ctl [POOL_SIZE+1];
  logic [IW-1:0] link_hnd [POOL_SIZE+1];
  logic [CW-1:0] link_cnt [POOL_SIZE+1];
  logic [POOL_SIZE-1:0] go_vec;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign launch      = accept &&
                       ((in_ch.req_type == REQ_ACQUIRE) || (in_ch.req_type == REQ_EOF));

  assign in_key = {in_ch.key_usage, in_ch.key_format, in_ch.key_height, in_ch.key_width};
  // Cell 0 sees the key in the accept cycle, before key_r is loaded.
  assign key_bc = (state_r == S_IDLE) ? in_key : key_r;

  assign hin_x   = CMPW'(in_ch.handle_in);
  assign ec_x    = CMPW'(entry_count_r);
  assign rel_ok  = in_ch.handle_valid && (hin_x < ec_x);
  assign rel_go  = accept && (in_ch.req_type == REQ_RELEASE) && rel_ok;
  assign clr_go  = accept && (in_ch.req_type == REQ_CLEAR);
  assign rel_idx = hin_x[IW-1:0];

  // Token fields in order: go, eof, done, created.
  assign link_ctl[0] = {launch, (in_ch.req_type == REQ_EOF), 1'b0, 1'b0};
  assign link_hnd[0] = '0;
  assign link_cnt[0] = '0;

  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
    krp_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .key_i         (key_bc),
      .entry_count_i (entry_count_r),
      .rel_i         (rel_go),
      .rel_idx_i     (rel_idx),
      .clr_i         (clr_go),
      .tin_ctl_i     (link_ctl[i]),
      .tin_hnd_i     (link_hnd[i]),
      .tin_cnt_i     (link_cnt[i]),
      .tout_ctl_o    (link_ctl[i+1]),
      .tout_hnd_o    (link_hnd[i+1]),
      .tout_cnt_o    (link_cnt[i+1])
    );
    assign go_vec[i] = link_ctl[i+1].go;
  end

  assign tail_hnd_x = HXW'(link_hnd[POOL_SIZE]);
  assign tail_cnt_x = FXW'(link_cnt[POOL_SIZE]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // In S_HOLD the output register is reloaded below instead.
      if (out_valid_r && out_ch.ready && (state_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            key_r        <= in_key;
            res_handle_r <= '0;
            res_freed_r  <= '0;
            case (in_ch.req_type)
              REQ_ACQUIRE, REQ_EOF: begin
                state_r <= S_SCAN;
              end
              REQ_RELEASE: begin
                res_status_r <= rel_ok ? STAT_RELEASED : STAT_IGNORED;
                state_r      <= S_HOLD;
              end
              default: begin
                res_status_r  <= STAT_CLEARED;
                entry_count_r <= '0;
                state_r       <= S_HOLD;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (link_ctl[POOL_SIZE].go) begin
            state_r <= S_HOLD;
            if (link_ctl[POOL_SIZE].eof) begin
              res_status_r <= STAT_FRAME;
              res_freed_r  <= tail_cnt_x[FREED_W-1:0];
            end else if (link_ctl[POOL_SIZE].done) begin
              res_handle_r <= tail_hnd_x[HANDLE_W-1:0];
              if (link_ctl[POOL_SIZE].created) begin
                res_status_r  <= STAT_CREATED;
                entry_count_r <= entry_count_r + CW'(1);
              end else begin
                res_status_r <= STAT_REUSED;
              end
            end else begin
              res_status_r <= STAT_FULL;
            end
          end
        end
        S_HOLD: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_handle_r <= res_handle_r;
            out_freed_r  <= res_freed_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.handle_out  = out_handle_r;
  assign out_ch.freed_count = out_freed_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CW'(POOL_SIZE))
    else $error("live entry count exceeds pool size");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(go_vec) <= 1)
    else $error("more than one token in the cell row");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    link_ctl[POOL_SIZE].go |-> state_r == S_SCAN)
    else $error("token left the cell row outside a scan");

  a_scan_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !in_ch.ready)
    else $error("request accepted during a scan");
`endif

endmodule

`default_nettype wire

>>> tb/tb_keyed_resource_pool.sv
`timescale 1ns / 1ps

import krp_pkg::*;

typedef struct packed {
  logic [REQ_W-1:0]    req;
  logic [DIM_W-1:0]    width;
  logic [DIM_W-1:0]    height;
  logic [CODE_W-1:0]   fmt;
  logic [CODE_W-1:0]   usage;
  logic [HANDLE_W-1:0] handle;
  logic                handle_valid;
} pool_req_t;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle;
  logic [FREED_W-1:0]  freed;
} pool_result_t;

// Mirror of the pool contents and the queue of results the block still owes.
class pool_mirror #(int SLOTS = 64);
  key_t         keys[SLOTS];
  bit           busy[SLOTS];
  int unsigned  live;
  pool_result_t owed[$];
  int unsigned  errors;

  function void note_request(pool_req_t r);
    pool_result_t res;
    key_t         k;
    bit           hit;
    res = '0;
    hit = 1'b0;
    case (r.req)
      REQ_ACQUIRE: begin
        k = {r.usage, r.fmt, r.height, r.width};
        // The lowest free entry with an equal key wins.
        for (int i = 0; i < live; i++) begin
          if (!hit && !busy[i] && keys[i] == k) begin
            hit        = 1'b1;
            busy[i]    = 1'b1;
            res.status = STAT_REUSED;
            res.handle = HANDLE_W'(i);
          end
        end
        if (!hit) begin
          if (live >= SLOTS) begin
            res.status = STAT_FULL;
          end else begin
            keys[live] = k;
            busy[live] = 1'b1;
            res.status = STAT_CREATED;
            res.handle = HANDLE_W'(live);
            live++;
          end
        end
      end
      REQ_RELEASE: begin
        if (r.handle_valid && r.handle < live) begin
          busy[r.handle] = 1'b0;
          res.status     = STAT_RELEASED;
        end else begin
          res.status = STAT_IGNORED;
        end
      end
      REQ_EOF: begin
        for (int i = 0; i < live; i++) begin
          if (busy[i]) begin
            busy[i] = 1'b0;
            res.freed++;
          end
        end
        res.status = STAT_FRAME;
      end
      REQ_CLEAR: begin
        foreach (busy[i]) busy[i] = 1'b0;
        live       = 0;
        res.status = STAT_CLEARED;
      end
      default: ;
    endcase
    owed.push_back(res);
  endfunction

  function void compare(string what, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  function void check_result(pool_result_t got);
    pool_result_t want;
    if (owed.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat, expected none, actual status %0d handle %0d",
               $time, got.status, got.handle);
      return;
    end
    want = owed.pop_front();
    compare("status", want.status, got.status);
    compare("handle_out", want.handle, got.handle);
    compare("freed_count", want.freed, got.freed);
  endfunction

  function int pick_busy();
    int cand[$];
    for (int i = 0; i < live; i++) begin
      if (busy[i]) cand.push_back(i);
    end
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction
endclass

module tb_keyed_resource_pool;
  localparam int SLOTS          = 64;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 2 * SLOTS + 16;

  typedef enum int {MODE_CHURN, MODE_FILL, MODE_NOISE} mix_t;

  logic        clk;
  logic        rst_n;
  bit          calm = 1'b0;
  int unsigned results_taken = 0;
  int unsigned idle_cycles = 0;
  key_t        palette[8];

  pool_mirror #(SLOTS) mirror;

  krp_in_if  in_ch();
  krp_out_if out_ch();

  keyed_resource_pool #(.POOL_SIZE(SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  function automatic int unsigned pick_gap();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    // Mostly in the legal range, now and then any 15-bit pattern.
    if ($urandom_range(0, 7) == 0) return DIM_W'($urandom);
    return DIM_W'($urandom_range(0, 16384));
  endfunction

  function automatic key_t rand_key();
    return {CODE_W'($urandom), CODE_W'($urandom), rand_dim(), rand_dim()};
  endfunction

  function automatic pool_req_t rand_bits();
    pool_req_t r;
    r.req          = REQ_W'($urandom);
    r.width        = DIM_W'($urandom);
    r.height       = DIM_W'($urandom);
    r.fmt          = CODE_W'($urandom);
    r.usage        = CODE_W'($urandom);
    r.handle       = HANDLE_W'($urandom);
    r.handle_valid = 1'($urandom);
    return r;
  endfunction

  function automatic pool_req_t op_of(logic [REQ_W-1:0] req);
    pool_req_t r;
    r     = rand_bits();
    r.req = req;
    return r;
  endfunction

  function automatic pool_req_t acquire_of(key_t k);
    pool_req_t r;
    r = op_of(REQ_ACQUIRE);
    {r.usage, r.fmt, r.height, r.width} = k;
    return r;
  endfunction

  function automatic pool_req_t release_of(int h, bit ok);
    pool_req_t r;
    r              = op_of(REQ_RELEASE);
    r.handle       = HANDLE_W'(h);
    r.handle_valid = ok;
    return r;
  endfunction

  function automatic pool_req_t pick_request(mix_t mix);
    int        roll;
    int        h;
    pool_req_t r;
    roll = $urandom_range(0, 99);
    if (mix == MODE_NOISE) return rand_bits();
    if (roll < (mix == MODE_FILL ? 88 : 50)) begin
      if ($urandom_range(0, 9) < (mix == MODE_FILL ? 3 : 8))
        r = acquire_of(palette[$urandom_range(0, 7)]);
      else
        r = acquire_of(rand_key());
    end else if (roll < (mix == MODE_FILL ? 97 : 85)) begin
      // Mostly a live busy handle; otherwise null, unknown or already free.
      h = mirror.pick_busy();
      if (h >= 0 && $urandom_range(0, 4) != 0)
        r = release_of(h, 1'b1);
      else
        r = op_of(REQ_RELEASE);
    end else if (roll < (mix == MODE_FILL ? 100 : 97)) begin
      r = op_of(REQ_EOF);
    end else begin
      r = op_of(REQ_CLEAR);
    end
    return r;
  endfunction

  task automatic send(pool_req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= r.req;
    in_ch.key_width    <= r.width;
    in_ch.key_height   <= r.height;
    in_ch.key_format   <= r.fmt;
    in_ch.key_usage    <= r.usage;
    in_ch.handle_in    <= r.handle;
    in_ch.handle_valid <= r.handle_valid;
    do @(posedge clk); while (!in_ch.ready);
    mirror.note_request(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL keyed_resource_pool");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side. One long stall lets the block back up and block its input.
  initial begin : drain
    int unsigned  gap;
    bit           held;
    pool_result_t got;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (!held && results_taken == 200) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.status = out_ch.status;
      got.handle = out_ch.handle_out;
      got.freed  = out_ch.freed_count;
      mirror.check_result(got);
      results_taken++;
    end
  end

  initial begin : stimulus
    mix_t        mix;
    int unsigned sent;
    int unsigned seg_len;
    key_t        kmax;
    clk                 = 1'b0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= REQ_ACQUIRE;
    in_ch.key_width    <= '0;
    in_ch.key_height   <= '0;
    in_ch.key_format   <= '0;
    in_ch.key_usage    <= '0;
    in_ch.handle_in    <= '0;
    in_ch.handle_valid <= 1'b0;
    out_ch.ready       <= 1'b0;
    mirror = new();
    foreach (palette[i]) palette[i] = rand_key();
    kmax = {8'hFF, 8'hFF, 15'd16384, 15'd16384};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pool: null handle, unknown handle, a frame that frees nothing.
    send(release_of(0, 1'b0));
    send(release_of(63, 1'b1));
    send(op_of(REQ_EOF));
    // Key extremes, then a duplicate key while its entry is busy.
    send(acquire_of('0));
    send(acquire_of(kmax));
    send(acquire_of('1));
    send(acquire_of('0));
    // Release twice (the second hits an entry that is already free), then reuse.
    send(release_of(0, 1'b1));
    send(release_of(0, 1'b1));
    send(acquire_of('0));
    send(release_of(4, 1'b1));
    send(release_of(1, 1'b0));
    send(release_of(63, 1'b1));
    send(op_of(REQ_EOF));
    send(acquire_of(kmax));
    send(op_of(REQ_CLEAR));
    send(release_of(0, 1'b1));
    send(acquire_of('1));
    send(op_of(REQ_EOF));

    // Random segments; the first one uses the fill mix to push the pool toward full.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(0, 9);
      if (sent == 0 || (seg_len >= 5 && seg_len < 8))
        mix = MODE_FILL;
      else if (seg_len < 5)
        mix = MODE_CHURN;
      else
        mix = MODE_NOISE;
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) foreach (palette[i]) palette[i] = rand_key();
      seg_len = (mix == MODE_FILL) ? $urandom_range(60, 160) : $urandom_range(20, 120);
      repeat (seg_len) begin
        send(pick_request(mix));
        sent++;
      end
      if ($urandom_range(0, 2) == 0) begin
        send(op_of(REQ_CLEAR));
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    while (mirror.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("PASS keyed_resource_pool");
    end else begin
      $display("FAIL keyed_resource_pool");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/krp_pkg.sv
design/krp_in_if.sv
design/krp_out_if.sv
design/krp_cell.sv
design/keyed_resource_pool.sv
tb/tb_keyed_resource_pool.sv
